/* rtl/epwmp_pkg.sv */
// Shared types and constants for the weighted end-pick maximum block.
`timescale 1ns / 1ps

package epwmp_pkg;

  localparam int PRICE_W = 16;
  localparam int TOTAL_W = 28;

  typedef logic [PRICE_W-1:0] price_t;
  typedef logic [TOTAL_W-1:0] total_t;

  // Largest total the result port can carry; larger totals saturate here.
  localparam total_t TOTAL_MAX = '1;

  typedef struct packed {
    total_t best_total;
    logic   overflowed;
  } result_t;

endpackage

/* rtl/epwmp_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module epwmp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; a read at the written address returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/epwmp_front.sv */
// Front end: takes price transactions, fills a price bank and queues one job per row.
`timescale 1ns / 1ps

module epwmp_front #(
  parameter int MAX_ITEMS = 64,
  localparam int CNT_W = $clog2(MAX_ITEMS + 1),
  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
  localparam int JOB_W = CNT_W + 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  epwmp_pkg::price_t     price,
  input  logic                  last,
  output logic                  busy,
  output logic                  wr_en,
  output logic [IDX_W:0]        wr_addr,
  output epwmp_pkg::price_t     wr_data,
  output logic                  push,
  output logic [JOB_W-1:0]      push_data,
  input  logic                  queue_full,
  input  logic                  release_valid,
  input  logic                  release_bank
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_inc;
  logic             dropped;
  logic             wbank;
  logic [1:0]       bank_busy;
  logic [1:0]       bank_busy_next;
  logic             accept;
  logic             store;

  // Stall while the fill bank holds an unevaluated row or the job queue is full.
  assign busy   = bank_busy[wbank] || queue_full;
  assign accept = start && !busy;
  assign store  = (count != CNT_W'(MAX_ITEMS));

  assign count_inc = count + CNT_W'(1);

  // Write the price into the current bank when there is room.
  assign wr_en   = accept && store;
  assign wr_addr = {wbank, count[IDX_W-1:0]};
  assign wr_data = price;

  // Queue a job at the end of each row: item count, drop flag, bank.
  assign push      = accept && last;
  assign push_data = {(store ? count_inc : count), (dropped || !store), wbank};

  // Track which banks hold rows not yet evaluated.
  always_comb begin
    bank_busy_next = bank_busy;
    if (release_valid) begin
      bank_busy_next[release_bank] = 1'b0;
    end
    if (push) begin
      bank_busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      wbank     <= 1'b0;
      bank_busy <= '0;
    end else begin
      bank_busy <= bank_busy_next;
      if (accept) begin
        if (last) begin
          count   <= '0;
          dropped <= 1'b0;
          wbank   <= ~wbank;
        end else if (store) begin
          count <= count_inc;
        end else begin
          dropped <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/epwmp_job_fifo.sv */
// Two-entry job queue between the front end and the evaluation engine.
`timescale 1ns / 1ps

module epwmp_job_fifo #(
  parameter int WIDTH = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign pop_data = mem[rd_ptr];
  assign empty    = (fill == 2'd0);
  assign full     = fill[1];

  // Store entries.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("job popped from an empty queue");
`endif

endmodule

/* rtl/epwmp_back.sv */
// Evaluation engine: sweeps the interval table row by row and emits the best total.
`timescale 1ns / 1ps

module epwmp_back #(
  parameter int MAX_ITEMS = 64,
  localparam int CNT_W = $clog2(MAX_ITEMS + 1),
  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
  localparam int JOB_W = CNT_W + 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  input  logic [JOB_W-1:0]      job_data,
  output logic                  job_pop,
  output logic [IDX_W:0]        pl_addr,
  output logic [IDX_W:0]        pr_addr,
  input  epwmp_pkg::price_t     pl_data,
  input  epwmp_pkg::price_t     pr_data,
  output logic                  release_valid,
  output logic                  release_bank,
  output logic                  res_valid,
  output epwmp_pkg::result_t    res
);

  localparam int SUM_W  = $clog2(MAX_ITEMS * (MAX_ITEMS + 1) / 2 + 1);
  localparam int ACC_W  = epwmp_pkg::PRICE_W + SUM_W;
  localparam int PROD_W = epwmp_pkg::PRICE_W + CNT_W;
  localparam int CMP_W  = (ACC_W > epwmp_pkg::TOTAL_W) ? ACC_W : epwmp_pkg::TOTAL_W;
  localparam int BDEPTH = 2 ** IDX_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]       state;
  logic             drain;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] year;
  logic [IDX_W-1:0] idx;
  logic             bank;
  logic             dropped;

  logic             issue;
  logic [CNT_W-1:0] right;
  logic [CNT_W-1:0] last_idx;
  logic             pass_done;
  logic             row_done;

  // Stage 1: read data arrives
  logic             v1;
  logic             first1;
  logic             final1;
  logic [IDX_W-1:0] idx1;
  logic [CNT_W-1:0] year1;
  logic [ACC_W-1:0] ba_rd;
  logic [ACC_W-1:0] bb_rd;

  // Stage 2: products registered
  logic              v2;
  logic              first2;
  logic              final2;
  logic [IDX_W-1:0]  idx2;
  logic [PROD_W-1:0] prod_l;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  best_a2;
  logic [ACC_W-1:0]  best_b2;

  logic [ACC_W-1:0]  take_l;
  logic [ACC_W-1:0]  take_r;
  logic [ACC_W-1:0]  best_new;
  logic [CMP_W-1:0]  best_ext;
  epwmp_pkg::total_t best_sat;

  // Issue one cell per cycle in S_RUN: left end idx, right end idx + len - 1.
  assign issue     = (state == S_RUN);
  assign right     = CNT_W'(idx) + len - CNT_W'(1);
  assign last_idx  = n - len;
  assign pass_done = (CNT_W'(idx) == last_idx);
  assign row_done  = (len == n);

  assign pl_addr = {bank, idx};
  assign pr_addr = {bank, right[IDX_W-1:0]};

  assign job_pop       = (state == S_IDLE) && job_valid;
  assign release_valid = (state == S_DRAIN) && drain && row_done;
  assign release_bank  = bank;

  // Two copies of the rolling row give two reads per cycle: entries idx and idx + 1.
  epwmp_ram #(
    .WIDTH (ACC_W),
    .DEPTH (BDEPTH)
  ) u_row_a (
    .clk   (clk),
    .we    (v2),
    .waddr (idx2),
    .wdata (best_new),
    .raddr (idx),
    .rdata (ba_rd)
  );

  epwmp_ram #(
    .WIDTH (ACC_W),
    .DEPTH (BDEPTH)
  ) u_row_b (
    .clk   (clk),
    .we    (v2),
    .waddr (idx2),
    .wdata (best_new),
    .raddr (idx + IDX_W'(1)),
    .rdata (bb_rd)
  );

  // Sequencer: one pass per interval length, with a drain phase (S_DRAIN) between
  // passes so the next pass reads what this one wrote.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      drain <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (pass_done) begin
            state <= S_DRAIN;
            drain <= 1'b0;
          end
        end
        S_DRAIN: begin
          if (!drain) begin
            drain <= 1'b1;
          end else if (row_done) begin
            state <= S_IDLE;
          end else begin
            state <= S_RUN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Row counters: latch the job, walk cells, step to the next length.
  always_ff @(posedge clk) begin
    if (job_pop) begin
      n       <= job_data[JOB_W-1:2];
      dropped <= job_data[1];
      bank    <= job_data[0];
      len     <= CNT_W'(1);
      year    <= job_data[JOB_W-1:2];
      idx     <= '0;
    end else if (issue && !pass_done) begin
      idx <= idx + IDX_W'(1);
    end else if ((state == S_DRAIN) && drain && !row_done) begin
      len  <= len + CNT_W'(1);
      year <= year - CNT_W'(1);
      idx  <= '0;
    end
  end

  // Pipeline valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1        <= issue;
      v2        <= v1;
      res_valid <= v2 && final2;
    end
  end

  // Stage 1 payload: carry cell tags alongside the reads.
  always_ff @(posedge clk) begin
    first1 <= (len == CNT_W'(1));
    final1 <= row_done;
    idx1   <= idx;
    year1  <= year;
  end

  // Stage 2 payload: weight both ends by the turn number.
  always_ff @(posedge clk) begin
    first2  <= first1;
    final2  <= final1;
    idx2    <= idx1;
    prod_l  <= PROD_W'(pl_data) * PROD_W'(year1);
    prod_r  <= PROD_W'(pr_data) * PROD_W'(year1);
    best_a2 <= ba_rd;
    best_b2 <= bb_rd;
  end

  // Pick the better end; single-item intervals take the product alone.
  always_comb begin
    take_l   = ACC_W'(prod_l) + (first2 ? '0 : best_b2);
    take_r   = ACC_W'(prod_r) + (first2 ? '0 : best_a2);
    best_new = (take_l > take_r) ? take_l : take_r;
    best_ext = CMP_W'(best_new);
    best_sat = (best_ext > CMP_W'(epwmp_pkg::TOTAL_MAX)) ? epwmp_pkg::TOTAL_MAX
                                                         : best_ext[epwmp_pkg::TOTAL_W-1:0];
  end

  // Hold the final cell of the row as the result.
  always_ff @(posedge clk) begin
    if (v2 && final2) begin
      res.best_total <= best_sat;
      res.overflowed <= dropped;
    end
  end

`ifndef SYNTHESIS
  a_pop_on_empty_pipe: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> (!v1 && !v2))
    else $error("new row started while the cell pipeline was busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> !res_valid)
    else $error("result strobe held for more than one cycle");

  a_cell_in_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (({1'b0, CNT_W'(idx)} + {1'b0, len}) <= {1'b0, n}))
    else $error("cell issued outside the current row");
`endif

endmodule

/* rtl/end_pick_weighted_max_profit_top.sv */
// Top level of the weighted end-pick maximum block.
//
//   channel   handshake            payload
//   input     start / busy         price, last
//   result    done (1-cycle pulse) best_total, overflowed
//
// Loading accepts a price on each start while busy is low. After the last item of
// a row, the cell pipeline updates one table entry per cycle within a pass, with a
// drain phase after each interval length. Two price banks let the next row load
// while a row is evaluated; busy rises only when both banks hold pending rows.
// Reset (rst, synchronous) empties the queue and clears both banks' claims.
// done cannot be stalled: the result is valid for exactly that cycle.
`timescale 1ns / 1ps

module end_pick_weighted_max_profit_top #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  epwmp_pkg::price_t   price,
  input  logic                last,
  output logic                done,
  output epwmp_pkg::total_t   best_total,
  output logic                overflowed
);

  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int JOB_W  = CNT_W + 2;
  localparam int PDEPTH = 2 * (2 ** IDX_W);

  logic               wr_en;
  logic [IDX_W:0]     wr_addr;
  epwmp_pkg::price_t  wr_data;
  logic               push;
  logic [JOB_W-1:0]   push_data;
  logic               pop;
  logic [JOB_W-1:0]   pop_data;
  logic               q_empty;
  logic               q_full;
  logic               release_valid;
  logic               release_bank;
  logic [IDX_W:0]     pl_addr;
  logic [IDX_W:0]     pr_addr;
  epwmp_pkg::price_t  pl_data;
  epwmp_pkg::price_t  pr_data;
  epwmp_pkg::result_t res;

  epwmp_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .price         (price),
    .last          (last),
    .busy          (busy),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .push          (push),
    .push_data     (push_data),
    .queue_full    (q_full),
    .release_valid (release_valid),
    .release_bank  (release_bank)
  );

  epwmp_job_fifo #(
    .WIDTH (JOB_W)
  ) u_jobs (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Two copies of the price banks serve the left and right ends of a cell.
  epwmp_ram #(
    .WIDTH (epwmp_pkg::PRICE_W),
    .DEPTH (PDEPTH)
  ) u_price_l (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (pl_addr),
    .rdata (pl_data)
  );

  epwmp_ram #(
    .WIDTH (epwmp_pkg::PRICE_W),
    .DEPTH (PDEPTH)
  ) u_price_r (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (pr_addr),
    .rdata (pr_data)
  );

  epwmp_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (!q_empty),
    .job_data      (pop_data),
    .job_pop       (pop),
    .pl_addr       (pl_addr),
    .pr_addr       (pr_addr),
    .pl_data       (pl_data),
    .pr_data       (pr_data),
    .release_valid (release_valid),
    .release_bank  (release_bank),
    .res_valid     (done),
    .res           (res)
  );

  assign best_total = res.best_total;
  assign overflowed = res.overflowed;

endmodule
